>>> design/mmat_pkg.sv
package mmat_pkg;

  localparam int NUM_CH        = 8;
  localparam int CH_W          = 3;
  localparam int SAMPLE_W      = 16;
  localparam int AVG_DEPTH_DEF = 16;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_TARE = 1'b1
  } action_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    action_t                            action;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]    samples;
  } item_t;

endpackage

>>> design/multichannel_moving_average_tare_core.sv
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_ready    | in_action, in_sample_ch0 .. in_sample_ch7
// result   | out_valid / out_ready  | out_channel, out_average, out_tare, out_last
//
// every transaction gives eight results, channel 0 to 7, one per cycle unless the result
// side stalls, from the per-channel pass through the ring memory and sum update.
// out_valid follows acceptance through ring read, sum, multiply and output registers.
// reset is synchronous; ring rows carry valid flags, no clearing pass.
// a two-entry queue keeps taking transactions while the result side is stalled, until full.
module multichannel_moving_average_tare_core #(
  parameter int AVG_DEPTH = mmat_pkg::AVG_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch0,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch1,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch2,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch3,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch4,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch5,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch6,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch7,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mmat_pkg::CH_W-1:0]            out_channel,
  output logic signed [mmat_pkg::SAMPLE_W-1:0] out_average,
  output logic signed [mmat_pkg::SAMPLE_W-1:0] out_tare,
  output logic                                 out_last
);
  import mmat_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  always_comb begin
    in_item.action     = action_t'(in_action);
    in_item.samples[0] = in_sample_ch0;
    in_item.samples[1] = in_sample_ch1;
    in_item.samples[2] = in_sample_ch2;
    in_item.samples[3] = in_sample_ch3;
    in_item.samples[4] = in_sample_ch4;
    in_item.samples[5] = in_sample_ch5;
    in_item.samples[6] = in_sample_ch6;
    in_item.samples[7] = in_sample_ch7;
  end

  mmat_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mmat_back #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .out_average (out_average),
    .out_tare    (out_tare),
    .out_last    (out_last)
  );

endmodule

>>> design/mmat_ram.sv
module mmat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/mmat_front.sv
module mmat_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mmat_pkg::item_t in_item,
  output logic            q_valid,
  output mmat_pkg::item_t q_item,
  input  logic            q_pop
);
  import mmat_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  item_t            entry_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push;
  logic             pop;
  item_t            cls_item;

  assign in_ready = (cnt_r != QCW'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = entry_r[rptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // anything that is not a tare capture is a push
  always_comb begin
    cls_item         = in_item;
    cls_item.action  = (in_item.action == ACT_TARE) ? ACT_TARE : ACT_PUSH;
  end

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QAW'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QAW'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= cls_item;
    end
  end

endmodule

>>> design/mmat_back.sv
module mmat_back #(
  parameter int AVG_DEPTH = mmat_pkg::AVG_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  mmat_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mmat_pkg::CH_W-1:0]     out_channel,
  output logic [mmat_pkg::SAMPLE_W-1:0] out_average,
  output logic [mmat_pkg::SAMPLE_W-1:0] out_tare,
  output logic                          out_last
);
  import mmat_pkg::*;

  localparam int LOG_D   = $clog2(AVG_DEPTH);
  localparam int SLOT_W  = (AVG_DEPTH > 1) ? LOG_D : 1;
  localparam int SUM_W   = SAMPLE_W + LOG_D;
  localparam int MUL_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + MUL_W;
  localparam int SHIFT   = SUM_W + LOG_D;
  localparam int QUOT_W  = PROD_W - SHIFT;
  localparam int RAM_DEPTH = AVG_DEPTH * NUM_CH;
  localparam int RAM_AW  = $clog2(RAM_DEPTH);
  localparam logic [63:0] MAGIC64 =
    ((64'd1 << SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [MUL_W-1:0]  MAGIC_C  = MAGIC64[MUL_W-1:0];
  localparam logic [QUOT_W-1:0] QPOS_MAX = QUOT_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [QUOT_W-1:0] QNEG_MAX = QUOT_W'(1 << (SAMPLE_W - 1));

  logic                      adv;

  // stage a: channel stepper over the queue head
  logic [CH_W-1:0]           a_ch_r, a_ch_nxt;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic [SLOT_W+CH_W-1:0]    rd_full;

  // stage b: ring read data back, running sum update
  logic                      b_vld_r;
  logic [CH_W-1:0]           b_ch_r;
  logic                      b_push_r;
  logic [SLOT_W-1:0]         b_slot_r;
  sample_t                   b_sample_r;
  logic [SLOT_W+CH_W-1:0]    wr_full;
  logic [SAMPLE_W-1:0]       ram_rdata;
  sample_t                   b_old;
  logic signed [SUM_W-1:0]   b_cur;
  logic signed [SUM_W-1:0]   b_new;
  logic                      ring_we;
  logic signed [SUM_W-1:0]   sum_r [NUM_CH];
  logic [AVG_DEPTH-1:0]      row_vld_r;

  // stage c: magnitude
  logic                      c_vld_r;
  logic [CH_W-1:0]           c_ch_r;
  logic                      c_push_r;
  logic signed [SUM_W-1:0]   c_sum_r;
  logic [SUM_W-1:0]          c_mag;

  // stage d: reciprocal product, sign restore
  logic                      d_vld_r;
  logic [CH_W-1:0]           d_ch_r;
  logic                      d_push_r;
  logic                      d_neg_r;
  logic [PROD_W-1:0]         d_prod_r, d_prod_nxt;
  logic [QUOT_W-1:0]         d_quot;
  logic [SAMPLE_W-1:0]       d_avg;
  logic [SAMPLE_W-1:0]       tare_r [NUM_CH];

  logic                      out_valid_r;
  logic [CH_W-1:0]           out_channel_r;
  logic [SAMPLE_W-1:0]       out_average_r;
  logic [SAMPLE_W-1:0]       out_tare_r;
  logic                      out_last_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = q_valid && adv && (a_ch_r == CH_LAST);

  always_comb begin
    a_ch_nxt = a_ch_r;
    slot_nxt = slot_r;
    if (q_valid && adv) begin
      a_ch_nxt = (a_ch_r == CH_LAST) ? '0 : a_ch_r + 1'b1;
      if (a_ch_r == CH_LAST && q_item.action == ACT_PUSH) begin
        slot_nxt = (slot_r == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      end
    end
  end

  assign rd_full = {slot_r, a_ch_r};
  assign wr_full = {b_slot_r, b_ch_r};
  assign ring_we = adv && b_vld_r && b_push_r;

  mmat_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_full[RAM_AW-1:0]),
    .wdata (b_sample_r),
    .re    (q_valid && adv),
    .raddr (rd_full[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  // rows never written since reset read as zero
  always_comb begin
    b_old = row_vld_r[b_slot_r] ? sample_t'(ram_rdata) : '0;
    b_cur = sum_r[b_ch_r];
    b_new = b_cur - SUM_W'(b_old) + SUM_W'(b_sample_r);
  end

  assign c_mag      = c_sum_r[SUM_W-1] ? (~c_sum_r + 1'b1) : c_sum_r;
  assign d_prod_nxt = PROD_W'(c_mag) * PROD_W'(MAGIC_C);
  assign d_quot     = d_prod_r[PROD_W-1:SHIFT];
  assign d_avg      = d_neg_r ? (~d_quot[SAMPLE_W-1:0] + 1'b1) : d_quot[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ch_r      <= '0;
      slot_r      <= '0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        sum_r[i]  <= '0;
        tare_r[i] <= '0;
      end
    end else begin
      a_ch_r <= a_ch_nxt;
      slot_r <= slot_nxt;
      if (adv) begin
        b_vld_r     <= q_valid;
        c_vld_r     <= b_vld_r;
        d_vld_r     <= c_vld_r;
        out_valid_r <= d_vld_r;
        if (ring_we) begin
          sum_r[b_ch_r] <= b_new;
          if (b_ch_r == CH_LAST) begin
            row_vld_r[b_slot_r] <= 1'b1;
          end
        end
        if (d_vld_r && !d_push_r) begin
          tare_r[d_ch_r] <= d_avg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ch_r        <= a_ch_r;
      b_push_r      <= (q_item.action == ACT_PUSH);
      b_slot_r      <= slot_r;
      b_sample_r    <= sample_t'(q_item.samples[a_ch_r]);
      c_ch_r        <= b_ch_r;
      c_push_r      <= b_push_r;
      c_sum_r       <= b_push_r ? b_new : b_cur;
      d_ch_r        <= c_ch_r;
      d_push_r      <= c_push_r;
      d_neg_r       <= c_sum_r[SUM_W-1];
      d_prod_r      <= d_prod_nxt;
      out_channel_r <= d_ch_r;
      out_average_r <= d_avg;
      out_tare_r    <= d_push_r ? tare_r[d_ch_r] : d_avg;
      out_last_r    <= (d_ch_r == CH_LAST);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_average = out_average_r;
  assign out_tare    = out_tare_r;
  assign out_last    = out_last_r;

`ifndef SYNTH
  // results of one transaction leave in channel order with no gap
  a_ch_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_last_r) |=>
      (out_valid_r && out_channel_r == $past(out_channel_r) + 3'd1))
    else $error("result channels out of order");

  // a ring row once written never reads as cleared again
  a_row_keep: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((row_vld_r & $past(row_vld_r)) == $past(row_vld_r)))
    else $error("ring row valid flag dropped");

  // reciprocal quotient must stay inside the sample range
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> ((d_neg_r && d_quot <= QNEG_MAX) || (!d_neg_r && d_quot <= QPOS_MAX)))
    else $error("average quotient out of range");
`endif

endmodule

>>> tb/tb_boxcar_checker.sv
`timescale 1ns / 1ps
module boxcar_checker #(
  parameter int AVG_DEPTH = mmat_pkg::AVG_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_action,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch0,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch1,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch2,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch3,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch4,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch5,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch6,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] in_sample_ch7,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [mmat_pkg::CH_W-1:0]            out_channel,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] out_average,
  input  logic signed [mmat_pkg::SAMPLE_W-1:0] out_tare,
  input  logic                                 out_last,
  output int                                   fail_count,
  output int                                   pending
);
  import mmat_pkg::*;

  typedef struct {
    logic [CH_W-1:0] channel;
    sample_t         average;
    sample_t         tare;
    logic            last;
  } chan_result_t;

  chan_result_t channel_results[$];

  sample_t frame_hist [AVG_DEPTH][NUM_CH];
  int      oldest_slot;
  int      window_sum [NUM_CH];
  sample_t tare_hold  [NUM_CH];
  int      n_fail = 0;
  int      n_seen = 0;

  task automatic report_mismatch(input string msg);
    if (n_fail < 100) begin
      $display("mismatch: %s", msg);
    end
    n_fail++;
  endtask

  // apply one transaction to the window and queue the eight channel results
  task automatic apply_frame(input item_t it);
    chan_result_t r;
    sample_t      s;
    if (it.action == ACT_PUSH) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s = sample_t'(it.samples[c]);
        window_sum[c] = window_sum[c] - int'(frame_hist[oldest_slot][c]) + int'(s);
        frame_hist[oldest_slot][c] = s;
      end
      oldest_slot = (oldest_slot + 1) % AVG_DEPTH;
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        tare_hold[c] = sample_t'(window_sum[c] / AVG_DEPTH);
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      r.channel = CH_W'(c);
      r.average = sample_t'(window_sum[c] / AVG_DEPTH);
      r.tare    = tare_hold[c];
      r.last    = (c == NUM_CH - 1);
      channel_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    item_t        it;
    chan_result_t want;
    if (!rst_n) begin
      for (int r = 0; r < AVG_DEPTH; r++) begin
        for (int c = 0; c < NUM_CH; c++) begin
          frame_hist[r][c] = '0;
        end
      end
      for (int c = 0; c < NUM_CH; c++) begin
        window_sum[c] = 0;
        tare_hold[c]  = '0;
      end
      oldest_slot = 0;
      channel_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        it.action  = action_t'(in_action);
        it.samples = {in_sample_ch7, in_sample_ch6, in_sample_ch5, in_sample_ch4,
                      in_sample_ch3, in_sample_ch2, in_sample_ch1, in_sample_ch0};
        apply_frame(it);
      end
      if (out_valid && out_ready) begin
        if (channel_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", n_seen));
        end else begin
          want = channel_results.pop_front();
          if (out_channel !== want.channel) begin
            report_mismatch($sformatf("result %0d channel: expected %0d, got %0d",
                                      n_seen, want.channel, out_channel));
          end
          if (out_average !== want.average) begin
            report_mismatch($sformatf("result %0d ch %0d average: expected %0d, got %0d",
                                      n_seen, want.channel, want.average, out_average));
          end
          if (out_tare !== want.tare) begin
            report_mismatch($sformatf("result %0d ch %0d tare: expected %0d, got %0d",
                                      n_seen, want.channel, want.tare, out_tare));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("result %0d ch %0d last: expected %0b, got %0b",
                                      n_seen, want.channel, want.last, out_last));
          end
        end
        n_seen++;
      end
    end
    fail_count <= n_fail;
    pending    <= channel_results.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mmat_pkg::*;

  localparam int      QUIET_LIMIT = 2000;
  localparam int      RAND_ITEMS  = 100;
  localparam sample_t S_MAX       = 16'sh7fff;
  localparam sample_t S_MIN       = 16'sh8000;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_action = 1'b0;
  sample_t in_sample_ch0 = '0;
  sample_t in_sample_ch1 = '0;
  sample_t in_sample_ch2 = '0;
  sample_t in_sample_ch3 = '0;
  sample_t in_sample_ch4 = '0;
  sample_t in_sample_ch5 = '0;
  sample_t in_sample_ch6 = '0;
  sample_t in_sample_ch7 = '0;
  logic    out_ready = 1'b0;
  logic    in_ready;
  logic    out_valid;
  logic    out_last;
  logic [CH_W-1:0] out_channel;
  sample_t out_average;
  sample_t out_tare;

  int      fail_count;
  int      pending;
  sample_t next_frame [NUM_CH];
  int      burst_left = 0;
  int      ready_run  = 0;
  int      quiet      = 0;

  always #10 clk = ~clk;

  multichannel_moving_average_tare_core #(
    .AVG_DEPTH(AVG_DEPTH_DEF)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_sample_ch0(in_sample_ch0), .in_sample_ch1(in_sample_ch1),
    .in_sample_ch2(in_sample_ch2), .in_sample_ch3(in_sample_ch3),
    .in_sample_ch4(in_sample_ch4), .in_sample_ch5(in_sample_ch5),
    .in_sample_ch6(in_sample_ch6), .in_sample_ch7(in_sample_ch7),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .out_average(out_average), .out_tare(out_tare), .out_last(out_last)
  );

  boxcar_checker #(
    .AVG_DEPTH(AVG_DEPTH_DEF)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_sample_ch0(in_sample_ch0), .in_sample_ch1(in_sample_ch1),
    .in_sample_ch2(in_sample_ch2), .in_sample_ch3(in_sample_ch3),
    .in_sample_ch4(in_sample_ch4), .in_sample_ch5(in_sample_ch5),
    .in_sample_ch6(in_sample_ch6), .in_sample_ch7(in_sample_ch7),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .out_average(out_average), .out_tare(out_tare), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  // result side back-pressure: ready runs, short stalls, now and then a long one
  always @(posedge clk) begin
    int pick;
    if (ready_run == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_ready <= 1'b1;
        ready_run = $urandom_range(1, 24);
      end else if (pick < 90) begin
        out_ready <= 1'b0;
        ready_run = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        ready_run = $urandom_range(10, 30);
      end
    end else begin
      ready_run--;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("multichannel_moving_average_tare_core regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic sample_t rand_sample(input int flavor);
    case (flavor)
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(0, 80)) - 40);
      default: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
    endcase
  endfunction

  // mostly back-to-back or short gaps, a few long ones, plus bursts with none
  function automatic int next_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      burst_left = $urandom_range(8, 20);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic void fill_random(input int flavor);
    for (int c = 0; c < NUM_CH; c++) begin
      next_frame[c] = rand_sample(flavor < 0 ? $urandom_range(0, 2) : flavor);
    end
  endfunction

  // valid is lowered only when a gap follows, so it never toggles within a step
  task automatic send_frame(input action_t act, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_sample_ch0 <= next_frame[0];
    in_sample_ch1 <= next_frame[1];
    in_sample_ch2 <= next_frame[2];
    in_sample_ch3 <= next_frame[3];
    in_sample_ch4 <= next_frame[4];
    in_sample_ch5 <= next_frame[5];
    in_sample_ch6 <= next_frame[6];
    in_sample_ch7 <= next_frame[7];
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tare straight out of reset, samples must be ignored
    fill_random(0);
    send_frame(ACT_TARE, next_gap());

    // fill the whole window with full-scale values, even channels high, odd low
    for (int k = 0; k < AVG_DEPTH_DEF; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        next_frame[c] = (c % 2 == 0) ? S_MAX : S_MIN;
      end
      send_frame(ACT_PUSH, next_gap());
    end
    fill_random(0);
    send_frame(ACT_TARE, next_gap());

    // slot wraps here; a -1 replacing the oldest full-scale sample checks rounding toward zero
    for (int c = 0; c < NUM_CH; c++) begin
      next_frame[c] = sample_t'(-1);
    end
    send_frame(ACT_PUSH, next_gap());
    for (int c = 0; c < NUM_CH; c++) begin
      next_frame[c] = sample_t'(c % 2);
    end
    send_frame(ACT_PUSH, next_gap());
    fill_random(2);
    send_frame(ACT_TARE, next_gap());

    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) fill_random(0);
      else if (pick < 70) fill_random(1);
      else if (pick < 85) fill_random(2);
      else fill_random(-1);
      send_frame(($urandom_range(0, 99) < 15) ? ACT_TARE : ACT_PUSH, next_gap());
    end
    in_valid <= 1'b0;

    // pending is registered, so it lags behind the last accepted transaction
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (fail_count == 0) begin
      $display("multichannel_moving_average_tare_core regression: pass");
    end else begin
      $display("multichannel_moving_average_tare_core regression: fail");
    end
    $finish;
  end

endmodule

>>> multichannel_moving_average_tare_core.f
design/mmat_pkg.sv
design/mmat_ram.sv
design/mmat_front.sv
design/mmat_back.sv
design/multichannel_moving_average_tare_core.sv
tb/tb_boxcar_checker.sv
tb/tb_top.sv
